// ===== rtl/core/rso_pkg.sv =====
// ----------------------------------------------------------------------------
// rso_pkg
// Types, operation codes and modulo-2^32 sequence compares shared by the
// receive segment order table.
// ----------------------------------------------------------------------------
package rso_pkg;

	// One held byte region: start sequence, end sequence, send-order number.
	typedef struct packed {
		logic [31:0] start;
		logic [31:0] stop;
		logic [31:0] order;
	} region_t;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DISCARD = 2'd1,
		OP_INIT    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_ENQ  = 2'd1,
		ST_DROP = 2'd2,
		ST_DONE = 2'd3
	} state_t;

	// Control handed from the head controller to the row of cells.
	typedef struct packed {
		logic shift;
		logic set_head_start;
	} chain_ctl_t;

	// a precedes b when the wrapped difference is negative.
	function automatic logic mod_less(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] diff;
		diff = a - b;
		return diff[31];
	endfunction

	function automatic logic mod_le(input logic [31:0] a, input logic [31:0] b);
		return (a == b) || mod_less(a, b);
	endfunction

endpackage

// ===== rtl/core/rso_req_if.sv =====
// ----------------------------------------------------------------------------
// rso_req_if
// Request channel of the segment order table: one operation per beat.
// ----------------------------------------------------------------------------
interface rso_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] seq_num;
	logic [15:0] payload_len;
	logic [31:0] send_order;

	modport source (output valid, operation, seq_num, payload_len, send_order, input ready);
	modport sink   (input valid, operation, seq_num, payload_len, send_order, output ready);
endinterface

// ===== rtl/core/rso_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rso_rsp_if
// Response channel of the segment order table: one status beat per request.
// ----------------------------------------------------------------------------
interface rso_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] next_expected;
	logic [31:0] window_low;
	logic [31:0] window_high;
	logic        dup_dropped;
	logic        table_full;
	logic        cut_out_of_range;

	modport source (output valid, next_expected, window_low, window_high, dup_dropped,
		table_full, cut_out_of_range, input ready);
	modport sink   (input valid, next_expected, window_low, window_high, dup_dropped,
		table_full, cut_out_of_range, output ready);
endinterface

// ===== rtl/core/rx_segment_order_table.sv =====
// ----------------------------------------------------------------------------
// rx_segment_order_table
// Sorted table of received byte regions with window edges and an in-order
// send counter.
// ----------------------------------------------------------------------------
// The table holds up to TABLE_ENTRIES regions in a row of cells kept sorted
// by start sequence under wrapping 32-bit comparison. One request beat is
// taken at a time and answered by exactly one response beat. An enqueue
// rotates the whole row once past the head controller: the controller sees
// one region per cycle, splices the new region in at its sorted place,
// refreshes the window edges and advances the in-order counter as the
// regions go by. A discard whose cut point lies within the window drops
// regions from the head one per cycle; a discard whose cut point lies
// outside the window, an initialise and an unknown operation go straight
// to the response. The next request is accepted as soon as the response
// is registered, even while that response is still waiting to be taken;
// if a previous response is still unclaimed when a new one is ready, the
// block holds until it goes. There is no clearing pass after reset: slots
// beyond the fill count are never looked at.
// ----------------------------------------------------------------------------
module rx_segment_order_table import rso_pkg::*; #(
	parameter int unsigned TABLE_ENTRIES = 16
) (
	input  logic clk,
	input  logic arst_n,
	rso_req_if.sink   req,
	rso_rsp_if.source rsp
);

	localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(TABLE_ENTRIES - 1);

	// Control state.
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] slot_q;
	logic [31:0]      low_q, high_q, exp_q;
	logic             match_q, found_q, ins_q;
	logic             dup_q, full_q, oor_q;
	logic             rsp_valid_q;

	// Operands of the request under way.
	logic [31:0]      seq_q, stop_new_q, ord_q;
	region_t          carry_q;

	// Response payload.
	logic [31:0]      rsp_exp_q, rsp_low_q, rsp_high_q;
	logic             rsp_dup_q, rsp_full_q, rsp_oor_q;

	region_t          head, tail, new_region;
	chain_ctl_t       chain_ctl;
	logic [31:0]      head_start;

	logic             accept, rsp_free;
	op_t              req_op;
	logic             req_oor;
	logic             head_valid, at_pos, is_dup, do_ins, out_valid;
	logic             drop_now, keep_start;
	logic             count_full;

	assign req_op     = op_t'(req.operation);
	assign accept     = req.valid && req.ready;
	assign rsp_free   = !rsp_valid_q || rsp.ready;
	assign count_full = (count_q == FULL_COUNT);
	assign req_oor    = !(mod_le(low_q, req.seq_num) && mod_le(req.seq_num, high_q));

	assign new_region = '{start: seq_q, stop: stop_new_q, order: ord_q};

	// Enqueue pass: the slot at the head is live if it lies below the fill
	// count. The sorted place is the first slot that is empty or whose start
	// does not precede the new start; a matching start there is a duplicate.
	assign head_valid = ({1'b0, CNT_W'(slot_q)} < {1'b0, count_q});
	assign at_pos     = !found_q && (!head_valid || !mod_less(head.start, seq_q));
	assign is_dup     = at_pos && head_valid && (head.start == seq_q);
	assign do_ins     = at_pos && !is_dup && !count_full;

	// Once the new region is in, each region comes out one slot later, so the
	// live part of the output stream grows by one.
	always_comb begin
		if (do_ins || ins_q) begin
			out_valid = ({1'b0, CNT_W'(slot_q)} <= {1'b0, count_q});
		end else begin
			out_valid = head_valid;
		end
	end

	// Discard: regions ending at or before the cut leave the head one by one.
	assign drop_now   = (count_q != '0) && mod_le(head.stop, seq_q);
	assign keep_start = !mod_le(head.start, seq_q) && mod_less(seq_q, head.stop);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_op)
						OP_ENQUEUE: state_d = ST_ENQ;
						OP_DISCARD: state_d = req_oor ? ST_DONE : ST_DROP;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_ENQ: begin
				if (slot_q == LAST_SLOT) begin
					state_d = ST_DONE;
				end
			end
			ST_DROP: begin
				if (!drop_now) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the state machine: handshake and row control.
	always_comb begin
		req.ready                = 1'b0;
		chain_ctl.shift          = 1'b0;
		chain_ctl.set_head_start = 1'b0;
		tail                     = head;
		head_start               = seq_q;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
			end
			ST_ENQ: begin
				chain_ctl.shift = 1'b1;
				if (do_ins) begin
					tail = new_region;
				end else if (ins_q) begin
					tail = carry_q;
				end
			end
			ST_DROP: begin
				chain_ctl.shift          = drop_now;
				chain_ctl.set_head_start = !drop_now && (count_q != '0) && !keep_start;
			end
			default: begin
			end
		endcase
	end

	rso_chain #(.ENTRIES(TABLE_ENTRIES)) u_chain (
		.clk       (clk),
		.ctl       (chain_ctl),
		.tail      (tail),
		.head_start(head_start),
		.head      (head)
	);

	// Control and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			slot_q      <= '0;
			low_q       <= '0;
			high_q      <= '0;
			exp_q       <= 32'd1;
			match_q     <= 1'b0;
			found_q     <= 1'b0;
			ins_q       <= 1'b0;
			dup_q       <= 1'b0;
			full_q      <= 1'b0;
			oor_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						slot_q  <= '0;
						found_q <= 1'b0;
						ins_q   <= 1'b0;
						dup_q   <= 1'b0;
						full_q  <= (req_op == OP_ENQUEUE) && count_full;
						oor_q   <= (req_op == OP_DISCARD) && req_oor;
						match_q <= (exp_q == req.send_order);
						case (req_op)
							OP_INIT: begin
								low_q  <= req.seq_num;
								high_q <= req.seq_num;
								exp_q  <= 32'd1;
							end
							default: begin
							end
						endcase
					end
				end
				ST_ENQ: begin
					slot_q <= slot_q + 1'b1;
					if (at_pos) begin
						found_q <= 1'b1;
					end
					if (is_dup) begin
						dup_q <= 1'b1;
					end
					if (do_ins) begin
						ins_q <= 1'b1;
					end
					// Edges and the in-order counter follow the final table order.
					if (out_valid) begin
						if (slot_q == '0) begin
							low_q <= tail.start;
						end
						high_q <= tail.stop;
						if (match_q && (tail.order == exp_q)) begin
							exp_q <= exp_q + 32'd1;
						end
					end
					if (slot_q == LAST_SLOT) begin
						count_q <= count_q + CNT_W'(ins_q || do_ins);
					end
				end
				ST_DROP: begin
					if (drop_now) begin
						count_q <= count_q - 1'b1;
					end else if (count_q != '0) begin
						low_q <= keep_start ? head.start : seq_q;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
			if (state_q != ST_DONE && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Operands and response payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q      <= req.seq_num;
			stop_new_q <= req.seq_num + {16'd0, req.payload_len};
			ord_q      <= req.send_order;
		end
		if (state_q == ST_ENQ && (do_ins || ins_q)) begin
			carry_q <= head;
		end
		if (state_q == ST_DONE && rsp_free) begin
			rsp_exp_q  <= exp_q;
			rsp_low_q  <= low_q;
			rsp_high_q <= high_q;
			rsp_dup_q  <= dup_q;
			rsp_full_q <= full_q && !dup_q;
			rsp_oor_q  <= oor_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.next_expected    = rsp_exp_q;
	assign rsp.window_low       = rsp_low_q;
	assign rsp.window_high      = rsp_high_q;
	assign rsp.dup_dropped      = rsp_dup_q;
	assign rsp.table_full       = rsp_full_q;
	assign rsp.cut_out_of_range = rsp_oor_q;

`ifndef SYNTH
	// The fill count never runs past the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("region count exceeds table size");

	// The fill count moves by at most one region per cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |->
			(count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1))
		else $error("region count jumped");

	// A response beat only appears after the block has finished a request.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_DONE))
		else $error("response raised outside completion");

	// Insertion and duplicate detection are exclusive within one enqueue.
	a_ins_dup: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ENQ |-> !(ins_q && dup_q))
		else $error("region both inserted and dropped");
`endif

endmodule

// ===== rtl/core/rso_cell.sv =====
// ----------------------------------------------------------------------------
// rso_cell
// One table slot. Takes its right-hand neighbour's region on a shift; the
// head slot may also have its start rewritten in place.
// ----------------------------------------------------------------------------
module rso_cell import rso_pkg::*; (
	input  logic       clk,
	input  chain_ctl_t ctl,
	input  region_t    din,
	input  logic [31:0] head_start,
	output region_t    q
);

	region_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= din;
		end else if (ctl.set_head_start) begin
			entry_q.start <= head_start;
		end
	end

	assign q = entry_q;

endmodule

// ===== rtl/core/rso_chain.sv =====
// ----------------------------------------------------------------------------
// rso_chain
// Row of table slots. On a shift every slot takes its right-hand neighbour,
// the last slot takes the tail region and the head region leaves at slot 0.
// ----------------------------------------------------------------------------
module rso_chain import rso_pkg::*; #(
	parameter int unsigned ENTRIES = 16
) (
	input  logic        clk,
	input  chain_ctl_t  ctl,
	input  region_t     tail,
	input  logic [31:0] head_start,
	output region_t     head
);

	region_t link [ENTRIES];

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		chain_ctl_t cell_ctl;
		region_t    cell_din;

		assign cell_ctl.shift          = ctl.shift;
		assign cell_ctl.set_head_start = (i == 0) ? ctl.set_head_start : 1'b0;

		if (i == ENTRIES - 1) begin : g_tail
			assign cell_din = tail;
		end else begin : g_mid
			assign cell_din = link[i + 1];
		end

		rso_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.din       (cell_din),
			.head_start(head_start),
			.q         (link[i])
		);
	end

	assign head = link[0];

endmodule
